// ===== src/aeha_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the AEHA infrared frame decoder: register indexes,
// reset values, record kinds and the tolerance window compare. No dependencies.
package aeha_pkg;

  localparam int unsigned MAX_DATA_DEFAULT = 32;

  localparam int unsigned US_W   = 15;
  localparam int unsigned TOL_W  = 12;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER_SPACE = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL  = 4'd7;

  localparam logic [US_W-1:0]  RST_HEADER_MARK   = 15'd3400;
  localparam logic [US_W-1:0]  RST_HEADER_SPACE  = 15'd1700;
  localparam logic [US_W-1:0]  RST_BIT_MARK      = 15'd425;
  localparam logic [US_W-1:0]  RST_ONE_SPACE     = 15'd1275;
  localparam logic [US_W-1:0]  RST_ZERO_SPACE    = 15'd425;
  localparam logic [US_W-1:0]  RST_TRAILER_SPACE = 15'd8000;
  localparam logic [TOL_W-1:0] RST_TOLERANCE     = 12'd150;
  localparam logic             RST_ACTIVE_LEVEL  = 1'b0;

  localparam logic [KIND_W-1:0] KIND_CUST = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PAR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DATA = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DONE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERR  = 3'd4;

  typedef struct packed {
    logic hdr;
    logic one;
    logic zero;
    logic trl;
    logic last;
  } pair_class_t;

  function automatic logic near_to(input logic [US_W-1:0] d, input logic [US_W-1:0] t,
                                   input logic [TOL_W-1:0] m);
    logic [US_W:0] d_ext;
    logic [US_W:0] t_ext;
    logic [US_W:0] m_ext;
    d_ext = {1'b0, d};
    t_ext = {1'b0, t};
    m_ext = (US_W+1)'(m);
    return (d_ext <= t_ext + m_ext) && (d_ext + m_ext >= t_ext);
  endfunction

  function automatic logic [3:0] nibble_xor(input logic [WORD_W-1:0] c);
    return c[15:12] ^ c[11:8] ^ c[7:4] ^ c[3:0];
  endfunction

endpackage

// ===== src/aeha_ir_frame_decoder.sv =====
`timescale 1ns / 1ps
// AEHA infrared frame decoder top level: pair classifier, frame sequencer
// and output register. Depends on aeha_pkg.
//
// Usage:
//  in_*  : one mark/space pulse pair per transfer; in_tlast marks the final
//          pair of a captured buffer.
//  out_* : zero or one record per pair (customer, parity, data, done, error);
//          out_tlast is set on done and error records.
//  cfg_* : register writes, always ready; write only while the block is idle.
// A pair is classified as it is accepted into the stage register; the frame
// sequencer then moves its record, if any, from there to the output register.
// Throughput: one pair per cycle while no held record stalls the output; the
// window compares sit in front of the stage register, the frame sequencer behind it.
// Reset (rst_n low, synchronous) restores the register defaults and waits for
// a header. When out_tready is low, the held record stalls the sequencer and
// the stage register; in_tready drops only once the stage register is full.
module aeha_ir_frame_decoder #(
  parameter int unsigned MAX_DATA = aeha_pkg::MAX_DATA_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // first_level[0], first_us[15:1], second_level[16], second_us[31:17]
  input  logic [31:0]                         in_tdata,
  input  logic                                in_tlast,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // value[15:0], data_index[21:16], items_used[31:22]
  output logic [31:0]                         out_tdata,
  // record_kind[2:0]
  output logic [aeha_pkg::KIND_W-1:0]         out_tuser,
  output logic                                out_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aeha_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aeha_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import aeha_pkg::*;

  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_CUST = 3'd1;
  localparam logic [2:0] PH_PAR  = 3'd2;
  localparam logic [2:0] PH_NIB  = 3'd3;
  localparam logic [2:0] PH_BYTE = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;

  localparam logic [IDX_W-1:0] MAX_DATA_V = IDX_W'(MAX_DATA);
  localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

  logic [US_W-1:0]  hdr_mark_r, hdr_space_r, bit_mark_r, one_space_r, zero_space_r;
  logic [US_W-1:0]  trl_space_r;
  logic [TOL_W-1:0] tol_r;
  logic             act_lvl_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_mark_r   <= RST_HEADER_MARK;
      hdr_space_r  <= RST_HEADER_SPACE;
      bit_mark_r   <= RST_BIT_MARK;
      one_space_r  <= RST_ONE_SPACE;
      zero_space_r <= RST_ZERO_SPACE;
      trl_space_r  <= RST_TRAILER_SPACE;
      tol_r        <= RST_TOLERANCE;
      act_lvl_r    <= RST_ACTIVE_LEVEL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEADER_MARK:   hdr_mark_r   <= cfg_data[US_W-1:0];
        REG_HEADER_SPACE:  hdr_space_r  <= cfg_data[US_W-1:0];
        REG_BIT_MARK:      bit_mark_r   <= cfg_data[US_W-1:0];
        REG_ONE_SPACE:     one_space_r  <= cfg_data[US_W-1:0];
        REG_ZERO_SPACE:    zero_space_r <= cfg_data[US_W-1:0];
        REG_TRAILER_SPACE: trl_space_r  <= cfg_data[US_W-1:0];
        REG_TOLERANCE:     tol_r        <= cfg_data[TOL_W-1:0];
        REG_ACTIVE_LEVEL:  act_lvl_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // classify the incoming pair
  logic            l0, l1, lv, bm;
  logic [US_W-1:0] d0, d1;
  pair_class_t     cls;

  assign l0 = in_tdata[0];
  assign d0 = in_tdata[15:1];
  assign l1 = in_tdata[16];
  assign d1 = in_tdata[31:17];
  assign lv = (l0 == act_lvl_r) && (l1 != act_lvl_r);
  assign bm = lv && near_to(d0, bit_mark_r, tol_r);

  always_comb begin
    cls.hdr  = lv && near_to(d0, hdr_mark_r, tol_r) && near_to(d1, hdr_space_r, tol_r);
    cls.one  = bm && near_to(d1, one_space_r, tol_r);
    cls.zero = bm && near_to(d1, zero_space_r, tol_r);
    cls.trl  = bm && (d1 == trl_space_r);
    cls.last = in_tlast;
  end

  // stage register
  pair_class_t s1_r;
  logic        s1_valid_r, s1_valid_nxt;
  logic        advance, s1_fire;

  assign advance   = !out_tvalid || out_tready;
  assign s1_fire   = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_fire) s1_valid_nxt = 1'b0;
    if (in_tvalid && in_tready) s1_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
    if (in_tvalid && in_tready) s1_r <= cls;
  end

  // frame sequencer
  logic [2:0]        phase_r, phase_nxt;
  logic [3:0]        bit_cnt_r, bit_cnt_nxt;
  logic [WORD_W-1:0] shift_r, shift_nxt;
  logic [WORD_W-1:0] cust_r, cust_nxt;
  logic [CNT_W-1:0]  pair_cnt_r, pair_cnt_nxt;
  logic [IDX_W-1:0]  data_cnt_r, data_cnt_nxt;

  logic              emit;
  logic [KIND_W-1:0] e_kind;
  logic [WORD_W-1:0] e_value;
  logic [IDX_W-1:0]  e_idx;
  logic              e_last;
  logic [WORD_W-1:0] sw_new;
  logic [3:0]        len_m1;

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    cust_nxt     = cust_r;
    pair_cnt_nxt = pair_cnt_r;
    data_cnt_nxt = data_cnt_r;
    emit    = 1'b0;
    e_kind  = KIND_ERR;
    e_value = '0;
    e_idx   = '0;
    e_last  = 1'b0;
    sw_new  = shift_r | (s1_r.one ? (WORD_W'(1) << bit_cnt_r) : '0);
    len_m1  = (phase_r == PH_CUST) ? 4'd15 : (phase_r == PH_BYTE) ? 4'd7 : 4'd3;
    if (s1_fire) begin
      unique case (phase_r)
        PH_SKIP: begin
          if (s1_r.last) phase_nxt = PH_WAIT;
        end
        PH_WAIT: begin
          bit_cnt_nxt  = '0;
          shift_nxt    = '0;
          cust_nxt     = '0;
          data_cnt_nxt = '0;
          pair_cnt_nxt = s1_r.hdr ? CNT_W'(1) : '0;
          if (!s1_r.hdr || s1_r.last) begin
            emit      = 1'b1;
            e_last    = 1'b1;
            phase_nxt = s1_r.last ? PH_WAIT : PH_SKIP;
          end else begin
            phase_nxt = PH_CUST;
          end
        end
        PH_CUST, PH_PAR, PH_NIB, PH_BYTE: begin
          if (phase_r == PH_BYTE && bit_cnt_r == '0 && s1_r.trl) begin
            emit      = 1'b1;
            e_kind    = KIND_DONE;
            e_idx     = data_cnt_r;
            e_last    = 1'b1;
            phase_nxt = s1_r.last ? PH_WAIT : PH_SKIP;
          end else if (!s1_r.one && !s1_r.zero) begin
            emit      = 1'b1;
            e_idx     = data_cnt_r;
            e_last    = 1'b1;
            phase_nxt = s1_r.last ? PH_WAIT : PH_SKIP;
          end else begin
            if (pair_cnt_r != CNT_MAX) pair_cnt_nxt = pair_cnt_r + CNT_W'(1);
            if (bit_cnt_r != len_m1) begin
              bit_cnt_nxt = bit_cnt_r + 4'd1;
              shift_nxt   = sw_new;
              if (s1_r.last) begin
                emit      = 1'b1;
                e_idx     = data_cnt_r;
                e_last    = 1'b1;
                phase_nxt = PH_WAIT;
              end
            end else begin
              bit_cnt_nxt = '0;
              shift_nxt   = '0;
              emit        = 1'b1;
              if (phase_r == PH_CUST) begin
                cust_nxt  = sw_new;
                e_kind    = KIND_CUST;
                e_value   = sw_new;
                phase_nxt = PH_PAR;
              end else if (phase_r == PH_PAR) begin
                if (sw_new != WORD_W'(nibble_xor(cust_r))) begin
                  e_idx     = data_cnt_r;
                  e_last    = 1'b1;
                  phase_nxt = s1_r.last ? PH_WAIT : PH_SKIP;
                end else begin
                  e_kind    = KIND_PAR;
                  e_value   = sw_new;
                  phase_nxt = PH_NIB;
                end
              end else if (data_cnt_r >= MAX_DATA_V) begin
                e_idx     = data_cnt_r;
                e_last    = 1'b1;
                phase_nxt = s1_r.last ? PH_WAIT : PH_SKIP;
              end else begin
                e_kind       = KIND_DATA;
                e_value      = sw_new;
                e_idx        = data_cnt_r;
                data_cnt_nxt = data_cnt_r + IDX_W'(1);
                phase_nxt    = PH_BYTE;
              end
              // a completed field on the final pair still ends in error
              if (s1_r.last && !e_last) begin
                e_kind    = KIND_ERR;
                e_value   = '0;
                e_idx     = data_cnt_nxt;
                e_last    = 1'b1;
                phase_nxt = PH_WAIT;
              end
            end
          end
        end
        default: phase_nxt = PH_WAIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_WAIT;
      bit_cnt_r  <= '0;
      shift_r    <= '0;
      cust_r     <= '0;
      pair_cnt_r <= '0;
      data_cnt_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      cust_r     <= cust_nxt;
      pair_cnt_r <= pair_cnt_nxt;
      data_cnt_r <= data_cnt_nxt;
    end
  end

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r;
  logic [WORD_W-1:0] out_value_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [CNT_W-1:0]  out_items_r;
  logic              out_last_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
    if (emit) begin
      out_kind_r  <= e_kind;
      out_value_r <= e_value;
      out_idx_r   <= e_idx;
      out_items_r <= pair_cnt_nxt;
      out_last_r  <= e_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_items_r, out_idx_r, out_value_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == ((out_tuser == KIND_DONE) || (out_tuser == KIND_ERR))))
    else $error("tlast does not match record kind");

  a_data_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    data_cnt_r <= MAX_DATA_V)
    else $error("data count beyond limit");

  a_data_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_DATA)) |-> (out_idx_r < MAX_DATA_V))
    else $error("data index beyond limit");

  a_stage_free: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with empty stage");

endmodule
